[design/pmst_pkg.sv]
// ----------------------------------------------------------------------------
// pmst_pkg
// Shared types, codes and helpers of the priority message slot table.
// ----------------------------------------------------------------------------
package pmst_pkg;

	localparam int SLOT_COUNT  = 8;
	localparam int IDX_W       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W       = $clog2(SLOT_COUNT + 1);
	localparam int SLOT_OUT_W  = 3;
	localparam int COUNT_OUT_W = 4;

	localparam logic [1:0] PRIO_NORMAL = 2'd0;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [2:0] {
		ACT_ENQUEUE   = 3'd0,
		ACT_EXPIRE    = 3'd1,
		ACT_GET       = 3'd2,
		ACT_MARK_READ = 3'd3,
		ACT_ACK       = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		STAT_DONE    = 2'd0,
		STAT_EVICTED = 2'd1,
		STAT_REFUSED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CMP_AGE_OVER = 2'd0,
		CMP_LESS     = 2'd1,
		CMP_EQUAL    = 2'd2
	} cmp_op_t;

	typedef struct packed {
		cmp_op_t     op;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
	} cmp_req_t;

	typedef struct packed {
		logic        read_flag;
		logic [31:0] id;
		logic [2:0]  source;
		logic [1:0]  prio;
		logic [31:0] created;
		logic [31:0] life;
	} entry_t;

	typedef struct packed {
		logic   write_entry;
		logic   set_read;
		logic   clear_valid;
		idx_t   idx;
		entry_t entry;
	} store_cmd_t;

	function automatic logic [SLOT_OUT_W-1:0] to_slot_out(input idx_t idx);
		logic [IDX_W+SLOT_OUT_W-1:0] wide;
		wide = {{SLOT_OUT_W{1'b0}}, idx};
		return wide[SLOT_OUT_W-1:0];
	endfunction

	function automatic logic [COUNT_OUT_W-1:0] to_count_out(input cnt_t cnt);
		logic [CNT_W+COUNT_OUT_W-1:0] wide;
		wide = {{COUNT_OUT_W{1'b0}}, cnt};
		return wide[COUNT_OUT_W-1:0];
	endfunction

endpackage

[design/priority_message_slot_table_top.sv]
// ----------------------------------------------------------------------------
// priority_message_slot_table_top
// Message slot table with enqueue/evict, expire, get, mark read and acknowledge.
// ----------------------------------------------------------------------------
// The sequencer takes each transaction in the idle state, walks the table
// slot by slot through the single shared compare unit, and then commits
// the table update and loads the result register. The block takes no new
// transaction until that commit is done. A finished result waits in
// the output register until it is taken, and the commit
// holds until that register is free. Enqueue takes the lowest free slot, or
// in a full table lets a non-normal message evict the oldest normal entry;
// ids count up and skip zero. Expire frees every entry whose wrapped age
// exceeds its time to live. Get and mark read pick the n-th valid slot in
// slot order, acknowledge removes the first valid entry with the given id.
// result_slot indexes the external text store. Each result carries the
// number of valid entries after the action.
module priority_message_slot_table_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic [31:0] now_ms,
	input  logic [2:0]  msg_source,
	input  logic [1:0]  msg_priority,
	input  logic [31:0] life_ms,
	input  logic [2:0]  display_index,
	input  logic [31:0] target_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] result_id,
	output logic [2:0]  result_slot,
	output logic [2:0]  found_source,
	output logic [1:0]  found_priority,
	output logic [31:0] found_created_ms,
	output logic [31:0] found_life_ms,
	output logic        found_read,
	output logic [3:0]  valid_count
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	state_t            state_q;
	pmst_pkg::idx_t    idx_q;
	pmst_pkg::action_t action_q;
	logic [31:0]       now_q;
	logic [2:0]        src_q;
	logic [1:0]        prio_q;
	logic [31:0]       life_q;
	logic [2:0]        didx_q;
	logic [31:0]       target_q;

	// scan findings
	logic              free_found_q;
	pmst_pkg::idx_t    free_idx_q;
	logic              old_found_q;
	pmst_pkg::idx_t    old_idx_q;
	logic [31:0]       old_created_q;
	logic              hit_q;
	pmst_pkg::idx_t    hit_idx_q;
	pmst_pkg::entry_t  hit_entry_q;
	pmst_pkg::cnt_t    seen_q;

	pmst_pkg::cnt_t    cnt_q;
	logic [31:0]       next_id_q;

	// result register
	logic              out_valid_q;
	logic [1:0]        status_q;
	logic [31:0]       result_id_q;
	logic [2:0]        result_slot_q;
	logic [2:0]        found_source_q;
	logic [1:0]        found_priority_q;
	logic [31:0]       found_created_q;
	logic [31:0]       found_life_q;
	logic              found_read_q;
	logic [3:0]        valid_count_q;

	pmst_pkg::cmp_req_t              cmp_req;
	logic                            cmp_hit;
	pmst_pkg::store_cmd_t            store_cmd;
	logic                            rd_valid;
	pmst_pkg::entry_t                rd_entry;
	logic [pmst_pkg::SLOT_COUNT-1:0] valid_vec;

	logic                            in_take;
	logic                            scan_last;
	logic                            commit_go;
	logic                            enq_write;
	logic [31:0]                     id_inc;
	logic [31:0]                     id_next;

	// commit-time result
	pmst_pkg::status_t               res_status;
	logic [31:0]                     res_id;
	pmst_pkg::idx_t                  res_idx;
	logic                            res_get;
	pmst_pkg::cnt_t                  cnt_next;

	pmst_cmp_unit u_cmp (
		.req (cmp_req),
		.hit (cmp_hit)
	);

	pmst_slot_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (store_cmd),
		.rd_idx    (idx_q),
		.rd_valid  (rd_valid),
		.rd_entry  (rd_entry),
		.valid_vec (valid_vec)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && (state_q == ST_IDLE);
	assign scan_last = (idx_q == pmst_pkg::IDX_W'(pmst_pkg::SLOT_COUNT - 1));
	assign commit_go = (state_q == ST_COMMIT) && (!out_valid_q || !out_stall);

	// ids skip zero on wrap
	assign id_inc  = next_id_q + 32'd1;
	assign id_next = (id_inc == 32'd0) ? 32'd1 : id_inc;

	// steer the shared compare unit by action
	always_comb begin
		cmp_req.op = pmst_pkg::CMP_LESS;
		cmp_req.a  = rd_entry.created;
		cmp_req.b  = old_created_q;
		cmp_req.c  = '0;
		unique case (action_q) inside
			pmst_pkg::ACT_EXPIRE: begin
				cmp_req.op = pmst_pkg::CMP_AGE_OVER;
				cmp_req.a  = now_q;
				cmp_req.b  = rd_entry.created;
				cmp_req.c  = rd_entry.life;
			end
			pmst_pkg::ACT_ACK: begin
				cmp_req.op = pmst_pkg::CMP_EQUAL;
				cmp_req.a  = rd_entry.id;
				cmp_req.b  = target_q;
			end
			default: begin
			end
		endcase
	end

	// commit decision and result fields
	always_comb begin
		enq_write  = 1'b0;
		res_status = pmst_pkg::STAT_REFUSED;
		res_id     = '0;
		res_idx    = '0;
		res_get    = 1'b0;
		cnt_next   = cnt_q;
		unique case (action_q) inside
			pmst_pkg::ACT_ENQUEUE: begin
				if (free_found_q) begin
					enq_write  = 1'b1;
					res_status = pmst_pkg::STAT_DONE;
					res_idx    = free_idx_q;
					res_id     = next_id_q;
					cnt_next   = cnt_q + pmst_pkg::cnt_t'(1);
				end else if (old_found_q && (prio_q != pmst_pkg::PRIO_NORMAL)) begin
					enq_write  = 1'b1;
					res_status = pmst_pkg::STAT_EVICTED;
					res_idx    = old_idx_q;
					res_id     = next_id_q;
				end
			end
			pmst_pkg::ACT_EXPIRE: begin
				res_status = pmst_pkg::STAT_DONE;
			end
			pmst_pkg::ACT_GET, pmst_pkg::ACT_MARK_READ: begin
				if (hit_q) begin
					res_status = pmst_pkg::STAT_DONE;
					res_idx    = hit_idx_q;
					res_id     = hit_entry_q.id;
					res_get    = (action_q == pmst_pkg::ACT_GET);
				end
			end
			pmst_pkg::ACT_ACK: begin
				if (hit_q) begin
					res_status = pmst_pkg::STAT_DONE;
					res_idx    = hit_idx_q;
					res_id     = target_q;
					cnt_next   = cnt_q - pmst_pkg::cnt_t'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// table updates: expire clears in flight, the rest at commit
	always_comb begin
		store_cmd.write_entry     = 1'b0;
		store_cmd.set_read        = 1'b0;
		store_cmd.clear_valid     = 1'b0;
		store_cmd.idx             = idx_q;
		store_cmd.entry.read_flag = 1'b0;
		store_cmd.entry.id        = next_id_q;
		store_cmd.entry.source    = src_q;
		store_cmd.entry.prio      = prio_q;
		store_cmd.entry.created   = now_q;
		store_cmd.entry.life      = life_q;
		if ((state_q == ST_SCAN) && (action_q == pmst_pkg::ACT_EXPIRE)) begin
			store_cmd.clear_valid = rd_valid && cmp_hit;
		end
		if (commit_go) begin
			store_cmd.idx = res_idx;
			if (enq_write) begin
				store_cmd.write_entry = 1'b1;
			end
			if ((action_q == pmst_pkg::ACT_MARK_READ) && hit_q) begin
				store_cmd.set_read = 1'b1;
			end
			if ((action_q == pmst_pkg::ACT_ACK) && hit_q) begin
				store_cmd.clear_valid = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			idx_q            <= '0;
			action_q         <= pmst_pkg::ACT_ENQUEUE;
			now_q            <= '0;
			src_q            <= '0;
			prio_q           <= '0;
			life_q           <= '0;
			didx_q           <= '0;
			target_q         <= '0;
			free_found_q     <= 1'b0;
			free_idx_q       <= '0;
			old_found_q      <= 1'b0;
			old_idx_q        <= '0;
			old_created_q    <= '0;
			hit_q            <= 1'b0;
			hit_idx_q        <= '0;
			hit_entry_q      <= '0;
			seen_q           <= '0;
			cnt_q            <= '0;
			next_id_q        <= 32'd1;
			out_valid_q      <= 1'b0;
			status_q         <= '0;
			result_id_q      <= '0;
			result_slot_q    <= '0;
			found_source_q   <= '0;
			found_priority_q <= '0;
			found_created_q  <= '0;
			found_life_q     <= '0;
			found_read_q     <= 1'b0;
			valid_count_q    <= '0;
		end else begin
			// drop the result once taken, unless the commit reloads it now
			if (out_valid_q && !out_stall && !commit_go) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						action_q     <= pmst_pkg::action_t'(action);
						now_q        <= now_ms;
						src_q        <= msg_source;
						prio_q       <= msg_priority;
						life_q       <= life_ms;
						didx_q       <= display_index;
						target_q     <= target_id;
						idx_q        <= '0;
						seen_q       <= '0;
						free_found_q <= 1'b0;
						old_found_q  <= 1'b0;
						hit_q        <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					unique case (action_q) inside
						pmst_pkg::ACT_ENQUEUE: begin
							if (!rd_valid && !free_found_q) begin
								free_found_q <= 1'b1;
								free_idx_q   <= idx_q;
							end
							// oldest normal entry, lowest slot on ties
							if (rd_valid && (rd_entry.prio == pmst_pkg::PRIO_NORMAL) &&
							    (!old_found_q || cmp_hit)) begin
								old_found_q   <= 1'b1;
								old_idx_q     <= idx_q;
								old_created_q <= rd_entry.created;
							end
						end
						pmst_pkg::ACT_EXPIRE: begin
							if (rd_valid && cmp_hit) begin
								cnt_q <= cnt_q - pmst_pkg::cnt_t'(1);
							end
						end
						pmst_pkg::ACT_GET, pmst_pkg::ACT_MARK_READ: begin
							if (rd_valid) begin
								if (!hit_q && (32'(seen_q) == 32'(didx_q))) begin
									hit_q       <= 1'b1;
									hit_idx_q   <= idx_q;
									hit_entry_q <= rd_entry;
								end
								seen_q <= seen_q + pmst_pkg::cnt_t'(1);
							end
						end
						pmst_pkg::ACT_ACK: begin
							if (rd_valid && cmp_hit && !hit_q) begin
								hit_q       <= 1'b1;
								hit_idx_q   <= idx_q;
								hit_entry_q <= rd_entry;
							end
						end
						default: begin
						end
					endcase
					if (scan_last) begin
						state_q <= ST_COMMIT;
					end else begin
						idx_q <= idx_q + pmst_pkg::idx_t'(1);
					end
				end
				ST_COMMIT: begin
					// hold until the result register is free
					if (commit_go) begin
						cnt_q            <= cnt_next;
						if (enq_write) begin
							next_id_q <= id_next;
						end
						out_valid_q      <= 1'b1;
						status_q         <= res_status;
						result_id_q      <= res_id;
						result_slot_q    <= pmst_pkg::to_slot_out(res_idx);
						found_source_q   <= res_get ? hit_entry_q.source : 3'd0;
						found_priority_q <= res_get ? hit_entry_q.prio : 2'd0;
						found_created_q  <= res_get ? hit_entry_q.created : 32'd0;
						found_life_q     <= res_get ? hit_entry_q.life : 32'd0;
						found_read_q     <= res_get ? hit_entry_q.read_flag : 1'b0;
						valid_count_q    <= pmst_pkg::to_count_out(cnt_next);
						state_q          <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign result_id        = result_id_q;
	assign result_slot      = result_slot_q;
	assign found_source     = found_source_q;
	assign found_priority   = found_priority_q;
	assign found_created_ms = found_created_q;
	assign found_life_ms    = found_life_q;
	assign found_read       = found_read_q;
	assign valid_count      = valid_count_q;

`ifndef SYNTHESIS
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) == $countones(valid_vec))
		else $error("valid count register out of step with valid bits");

	a_next_id_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		next_id_q != 32'd0)
		else $error("next id reached zero");

	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_COMMIT))
		else $error("result loaded outside commit");

	a_evict_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == pmst_pkg::STAT_EVICTED)) |->
		(32'(valid_count_q) == 32'(pmst_pkg::SLOT_COUNT % 16)))
		else $error("eviction reported with free slots");
`endif

endmodule

[design/pmst_cmp_unit.sv]
// ----------------------------------------------------------------------------
// pmst_cmp_unit
// Shared 32-bit compare unit: age check, less-than and equality.
// ----------------------------------------------------------------------------
module pmst_cmp_unit (
	input  pmst_pkg::cmp_req_t req,
	output logic               hit
);

	logic [31:0] age;

	// age wraps modulo 2^32
	assign age = req.a - req.b;

	always_comb begin
		unique case (req.op)
			pmst_pkg::CMP_AGE_OVER: hit = (age > req.c);
			pmst_pkg::CMP_LESS:     hit = (req.a < req.b);
			pmst_pkg::CMP_EQUAL:    hit = (req.a == req.b);
			default:                hit = 1'b0;
		endcase
	end

endmodule

[design/pmst_slot_store.sv]
// ----------------------------------------------------------------------------
// pmst_slot_store
// Slot storage: valid bits with reset, entry fields without reset.
// ----------------------------------------------------------------------------
module pmst_slot_store (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pmst_pkg::store_cmd_t             cmd,
	input  pmst_pkg::idx_t                   rd_idx,
	output logic                             rd_valid,
	output pmst_pkg::entry_t                 rd_entry,
	output logic [pmst_pkg::SLOT_COUNT-1:0]  valid_vec
);

	logic [pmst_pkg::SLOT_COUNT-1:0] valid_q;
	pmst_pkg::entry_t                entry_q [pmst_pkg::SLOT_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (cmd.write_entry) begin
				valid_q[cmd.idx] <= 1'b1;
			end
			if (cmd.clear_valid) begin
				valid_q[cmd.idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write_entry) begin
			entry_q[cmd.idx] <= cmd.entry;
		end
		if (cmd.set_read) begin
			entry_q[cmd.idx].read_flag <= 1'b1;
		end
	end

	assign rd_valid  = valid_q[rd_idx];
	assign rd_entry  = entry_q[rd_idx];
	assign valid_vec = valid_q;

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the priority message slot table. It keeps a model
// of the eight slots and the id counter, works out the reply to every accepted
// transaction, and checks every reply field against it. Directed runs cover
// the empty table, fill, refusal and eviction, lookup, acknowledge and expiry
// with a wrapped clock. Random runs follow with and without idle cycles.
// ----------------------------------------------------------------------------
module tb;

	// Priorities other than normal, used by the directed runs.
	localparam logic [1:0] PRIO_IMPORTANT = 2'd1;
	localparam logic [1:0] PRIO_ALERT     = 2'd3;

	// Action codes that the block does not serve.
	localparam logic [2:0] ACT_FIRST_UNUSED = 3'd5;
	localparam logic [2:0] ACT_LAST_CODE    = 3'd7;

	localparam int MAX_IDLE     = 9;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int REPORT_MAX   = 10;

	typedef struct packed {
		logic [2:0]  act;
		logic [31:0] now;
		logic [2:0]  src;
		logic [1:0]  prio;
		logic [31:0] life;
		logic [2:0]  didx;
		logic [31:0] target;
	} table_req_t;

	typedef struct packed {
		pmst_pkg::status_t stat;
		logic [31:0]       id;
		logic [2:0]        slot;
		logic [2:0]        src;
		logic [1:0]        prio;
		logic [31:0]       created;
		logic [31:0]       life;
		logic              rd_flag;
		logic [3:0]        count;
	} table_reply_t;

	typedef struct {
		logic        live;
		logic        rd_flag;
		logic [31:0] id;
		logic [2:0]  src;
		logic [1:0]  prio;
		logic [31:0] created;
		logic [31:0] life;
	} slot_rec_t;

	// Clock and reset.
	logic clk = 1'b0;
	logic arst_n;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Block ports.
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  action;
	logic [31:0] now_ms;
	logic [2:0]  msg_source;
	logic [1:0]  msg_priority;
	logic [31:0] life_ms;
	logic [2:0]  display_index;
	logic [31:0] target_id;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [31:0] result_id;
	logic [2:0]  result_slot;
	logic [2:0]  found_source;
	logic [1:0]  found_priority;
	logic [31:0] found_created_ms;
	logic [31:0] found_life_ms;
	logic        found_read;
	logic [3:0]  valid_count;

	priority_message_slot_table_top u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.action           (action),
		.now_ms           (now_ms),
		.msg_source       (msg_source),
		.msg_priority     (msg_priority),
		.life_ms          (life_ms),
		.display_index    (display_index),
		.target_id        (target_id),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.status           (status),
		.result_id        (result_id),
		.result_slot      (result_slot),
		.found_source     (found_source),
		.found_priority   (found_priority),
		.found_created_ms (found_created_ms),
		.found_life_ms    (found_life_ms),
		.found_read       (found_read),
		.valid_count      (valid_count)
	);

	// Model state: the slot table, the id counter and the replies still owed.
	slot_rec_t    msg_slots [pmst_pkg::SLOT_COUNT];
	logic [31:0]  next_msg_id;
	table_reply_t pending_replies[$];

	// Message clock that random traffic stamps; it advances a little per item.
	logic [31:0] clock_ms;
	// Idle cycles on both sides are drawn only while this is set.
	bit          pace_on;
	int          fail_count = 0;
	int          stall_left = 0;
	int          idle_cycles;

	// ------------------------------------------------------------------------
	// Table model: apply one transaction and return the reply it owes.
	// ------------------------------------------------------------------------
	function automatic table_reply_t apply_to_table(input table_req_t rq);
		table_reply_t r;
		int           pick;
		int           victim;
		int           seen;
		logic [31:0]  age;

		r = '0;
		r.stat = pmst_pkg::STAT_REFUSED;
		pick = -1;
		case (rq.act)
		pmst_pkg::ACT_ENQUEUE: begin
			// Take the lowest free slot.
			for (int i = 0; i < pmst_pkg::SLOT_COUNT; i++)
				if (pick < 0 && !msg_slots[i].live)
					pick = i;
			r.stat = pmst_pkg::STAT_DONE;
			if (pick < 0) begin
				// Full: find the oldest normal entry, lowest slot on ties.
				victim = -1;
				for (int i = 0; i < pmst_pkg::SLOT_COUNT; i++)
					if (msg_slots[i].live &&
							msg_slots[i].prio == pmst_pkg::PRIO_NORMAL &&
							(victim < 0 ||
							msg_slots[i].created < msg_slots[victim].created))
						victim = i;
				if (victim >= 0 && rq.prio != pmst_pkg::PRIO_NORMAL) begin
					pick = victim;
					r.stat = pmst_pkg::STAT_EVICTED;
				end else begin
					r.stat = pmst_pkg::STAT_REFUSED;
				end
			end
			if (pick >= 0) begin
				msg_slots[pick].live    = 1'b1;
				msg_slots[pick].rd_flag = 1'b0;
				msg_slots[pick].id      = next_msg_id;
				msg_slots[pick].src     = rq.src;
				msg_slots[pick].prio    = rq.prio;
				msg_slots[pick].created = rq.now;
				msg_slots[pick].life    = rq.life;
				r.id = next_msg_id;
				r.slot = 3'(pick);
				// Skip zero when the id counter wraps.
				next_msg_id = next_msg_id + 32'd1;
				if (next_msg_id == 32'd0)
					next_msg_id = 32'd1;
			end
		end
		pmst_pkg::ACT_EXPIRE: begin
			for (int i = 0; i < pmst_pkg::SLOT_COUNT; i++) begin
				age = rq.now - msg_slots[i].created;
				if (msg_slots[i].live && age > msg_slots[i].life)
					msg_slots[i].live = 1'b0;
			end
			r.stat = pmst_pkg::STAT_DONE;
		end
		pmst_pkg::ACT_GET, pmst_pkg::ACT_MARK_READ: begin
			seen = 0;
			for (int i = 0; i < pmst_pkg::SLOT_COUNT; i++) begin
				if (msg_slots[i].live) begin
					if (pick < 0 && seen == rq.didx)
						pick = i;
					seen++;
				end
			end
			if (pick >= 0) begin
				r.stat = pmst_pkg::STAT_DONE;
				r.id = msg_slots[pick].id;
				r.slot = 3'(pick);
				if (rq.act == pmst_pkg::ACT_GET) begin
					r.src     = msg_slots[pick].src;
					r.prio    = msg_slots[pick].prio;
					r.created = msg_slots[pick].created;
					r.life    = msg_slots[pick].life;
					r.rd_flag = msg_slots[pick].rd_flag;
				end else begin
					msg_slots[pick].rd_flag = 1'b1;
				end
			end
		end
		pmst_pkg::ACT_ACK: begin
			for (int i = 0; i < pmst_pkg::SLOT_COUNT; i++) begin
				if (pick < 0 && msg_slots[i].live && msg_slots[i].id == rq.target) begin
					pick = i;
					msg_slots[i].live = 1'b0;
					r.stat = pmst_pkg::STAT_DONE;
					r.id = rq.target;
					r.slot = 3'(i);
				end
			end
		end
		default: ;
		endcase
		for (int i = 0; i < pmst_pkg::SLOT_COUNT; i++)
			if (msg_slots[i].live)
				r.count = r.count + 4'd1;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------------

	// Fill every field at random so that unused fields toggle too.
	function automatic table_req_t random_fields();
		table_req_t rq;
		rq.act    = 3'($urandom_range(0, 4));
		rq.now    = $urandom();
		rq.src    = 3'($urandom_range(0, 7));
		rq.prio   = 2'($urandom_range(0, 3));
		rq.life   = $urandom();
		rq.didx   = 3'($urandom_range(0, 7));
		rq.target = $urandom();
		return rq;
	endfunction

	// Draw one random transaction. enq_pct weights enqueue, urgent_pct the
	// share of enqueued messages that are not normal.
	function automatic table_req_t draw_item(input int enq_pct, input int urgent_pct);
		table_req_t  rq;
		int          roll;
		int          n;
		logic [31:0] ids [pmst_pkg::SLOT_COUNT];

		rq = random_fields();
		roll = $urandom_range(0, 99);
		if (roll < enq_pct) begin
			rq.act = pmst_pkg::ACT_ENQUEUE;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 3)
				rq.act = 3'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_CODE));
			else if (roll < 20)
				rq.act = pmst_pkg::ACT_EXPIRE;
			else if (roll < 45)
				rq.act = pmst_pkg::ACT_GET;
			else if (roll < 65)
				rq.act = pmst_pkg::ACT_MARK_READ;
			else
				rq.act = pmst_pkg::ACT_ACK;
		end

		// Mostly follow the running clock so that ages stay meaningful.
		if ($urandom_range(0, 9) != 0) begin
			rq.now = clock_ms;
			clock_ms = clock_ms + 32'($urandom_range(0, 40));
		end

		case ($urandom_range(0, 3))
		0: rq.life = 32'($urandom_range(0, 200));
		1: rq.life = 32'($urandom_range(0, 3000));
		2: rq.life = $urandom();
		default: rq.life = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
		endcase

		if ($urandom_range(0, 99) < urgent_pct)
			rq.prio = 2'($urandom_range(1, 3));
		else
			rq.prio = pmst_pkg::PRIO_NORMAL;

		// Acknowledge a live id most of the time.
		if (rq.act == pmst_pkg::ACT_ACK && $urandom_range(0, 3) != 0) begin
			n = 0;
			for (int i = 0; i < pmst_pkg::SLOT_COUNT; i++) begin
				if (msg_slots[i].live) begin
					ids[n] = msg_slots[i].id;
					n++;
				end
			end
			if (n != 0)
				rq.target = ids[$urandom_range(0, n - 1)];
		end
		return rq;
	endfunction

	// Send one transaction: idle a random number of cycles, hold the payload
	// until it is taken, then record the reply it owes.
	task automatic send_item(input table_req_t rq);
		int gap;
		gap = pace_on ? $urandom_range(0, MAX_IDLE) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		action        <= rq.act;
		now_ms        <= rq.now;
		msg_source    <= rq.src;
		msg_priority  <= rq.prio;
		life_ms       <= rq.life;
		display_index <= rq.didx;
		target_id     <= rq.target;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_replies.push_back(apply_to_table(rq));
	endtask

	// Build and send a transaction with the given action; other fields random.
	task automatic send_action(input logic [2:0] act, input logic [31:0] now,
			input logic [31:0] target, input logic [2:0] didx);
		table_req_t rq;
		rq = random_fields();
		rq.act    = act;
		rq.now    = now;
		rq.target = target;
		rq.didx   = didx;
		send_item(rq);
	endtask

	task automatic send_enqueue(input logic [31:0] now, input logic [2:0] src,
			input logic [1:0] prio, input logic [31:0] life);
		table_req_t rq;
		rq = random_fields();
		rq.act  = pmst_pkg::ACT_ENQUEUE;
		rq.now  = now;
		rq.src  = src;
		rq.prio = prio;
		rq.life = life;
		send_item(rq);
	endtask

	// ------------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------------

	// Every lookup on an empty table misses; unused action codes are refused.
	task automatic test_empty_table();
		send_action(pmst_pkg::ACT_GET, $urandom(), $urandom(), 3'd0);
		send_action(pmst_pkg::ACT_MARK_READ, $urandom(), $urandom(), 3'd7);
		send_action(pmst_pkg::ACT_ACK, $urandom(), 32'd0, 3'd0);
		send_action(pmst_pkg::ACT_EXPIRE, 32'hFFFF_FFFF, $urandom(), 3'd0);
		send_action(ACT_LAST_CODE, $urandom(), $urandom(), 3'd0);
		send_action(ACT_FIRST_UNUSED, $urandom(), $urandom(), 3'd0);
	endtask

	// Fill all slots, refuse a normal message on a full table, then evict the
	// oldest normal entry for a non-normal message. Slots 1 and 3 share the
	// oldest creation time so the tie goes to the lower slot; slot 0 carries
	// the all-ones creation time.
	task automatic test_fill_and_evict();
		logic [31:0] born;
		logic [1:0]  prio;
		logic [31:0] life;
		for (int k = 0; k < pmst_pkg::SLOT_COUNT; k++) begin
			born = (k == 0) ? 32'hFFFF_FFFF : (k == 1 || k == 3) ? 32'h10 : 32'h100 + k;
			prio = (k == 2) ? PRIO_ALERT : (k == 5) ? PRIO_IMPORTANT : pmst_pkg::PRIO_NORMAL;
			life = (k == 0 || k == 7) ? 32'hFFFF_FFFF : 32'd0;
			send_enqueue(born, 3'(k), prio, life);
		end
		send_enqueue(32'h20, 3'd6, pmst_pkg::PRIO_NORMAL, 32'd0);
		send_enqueue(32'h20, 3'd1, 2'd2, 32'd0);
	endtask

	// Lookup by position, read flag, acknowledge by id and a wrapped expiry.
	task automatic test_lookup_and_ack();
		send_action(pmst_pkg::ACT_GET, $urandom(), $urandom(), 3'd7);
		send_action(pmst_pkg::ACT_MARK_READ, $urandom(), $urandom(), 3'd0);
		send_action(pmst_pkg::ACT_GET, $urandom(), $urandom(), 3'd0);
		send_action(pmst_pkg::ACT_ACK, $urandom(), msg_slots[4].id, 3'd0);
		send_action(pmst_pkg::ACT_ACK, $urandom(), 32'hFFFF_FFFF, 3'd0);
		// Age of the all-ones entry wraps to 0x21 here.
		send_action(pmst_pkg::ACT_EXPIRE, 32'h20, $urandom(), 3'd0);
		send_action(pmst_pkg::ACT_GET, $urandom(), $urandom(), 3'd7);
		send_action(pmst_pkg::ACT_GET, $urandom(), $urandom(), 3'd0);
	endtask

	task automatic test_mixed_traffic(input int n);
		for (int k = 0; k < n; k++)
			send_item(draw_item(35, 30));
	endtask

	// Same mix with no idle cycles on either side.
	task automatic test_back_to_back(input int n);
		pace_on = 1'b0;
		for (int k = 0; k < n; k++)
			send_item(draw_item(35, 30));
		pace_on = 1'b1;
	endtask

	// Keep the table full so eviction and both refusals come up often.
	task automatic test_urgent_flood(input int n);
		for (int k = 0; k < n; k++)
			send_item(draw_item(75, 70));
	endtask

	// Run the clock across the 32-bit wrap while entries age out.
	task automatic test_clock_wrap(input int n);
		clock_ms = 32'hFFFF_F000;
		for (int k = 0; k < n; k++)
			send_item(draw_item(40, 30));
	endtask

	// ------------------------------------------------------------------------
	// Result side: stall at random, check each reply against the oldest one
	// owed.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		table_reply_t got;
		table_reply_t want;
		if (out_valid && !out_stall) begin
			got.stat    = pmst_pkg::status_t'(status);
			got.id      = result_id;
			got.slot    = result_slot;
			got.src     = found_source;
			got.prio    = found_priority;
			got.created = found_created_ms;
			got.life    = found_life_ms;
			got.rd_flag = found_read;
			got.count   = valid_count;
			if (pending_replies.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_MAX)
					$display("%0t: reply with none owed: st=%0d id=%h slot=%0d cnt=%0d",
						$realtime, got.stat, got.id, got.slot, got.count);
			end else begin
				want = pending_replies.pop_front();
				if (got.stat !== want.stat || got.id !== want.id ||
						got.slot !== want.slot || got.src !== want.src ||
						got.prio !== want.prio || got.created !== want.created ||
						got.life !== want.life || got.rd_flag !== want.rd_flag ||
						got.count !== want.count) begin
					fail_count++;
					if (fail_count <= REPORT_MAX) begin
						$display({"%0t: expected st=%0d id=%h slot=%0d src=%0d",
							" pri=%0d cre=%h life=%h rd=%0d cnt=%0d"},
							$realtime, want.stat, want.id, want.slot, want.src,
							want.prio, want.created, want.life, want.rd_flag,
							want.count);
						$display({"%0t: actual   st=%0d id=%h slot=%0d src=%0d",
							" pri=%0d cre=%h life=%h rd=%0d cnt=%0d"},
							$realtime, got.stat, got.id, got.slot, got.src,
							got.prio, got.created, got.life, got.rd_flag,
							got.count);
					end
				end
			end
			// Draw the stall for the next reply.
			stall_left = pace_on ? $urandom_range(0, MAX_IDLE) : 0;
			out_stall <= (stall_left != 0);
		end else if (stall_left != 0) begin
			stall_left--;
			out_stall <= (stall_left != 0);
		end
	end

	// Watchdog: end the run when nothing moves on either side for too long.
	initial begin
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("priority_message_slot_table_top: mismatch");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------------
	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		action        = pmst_pkg::ACT_ENQUEUE;
		now_ms        = '0;
		msg_source    = '0;
		msg_priority  = pmst_pkg::PRIO_NORMAL;
		life_ms       = '0;
		display_index = '0;
		target_id     = '0;
		pace_on       = 1'b1;
		clock_ms      = '0;
		next_msg_id   = 32'd1;
		for (int i = 0; i < pmst_pkg::SLOT_COUNT; i++)
			msg_slots[i].live = 1'b0;

		// Hold reset low, then release it once.
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_fill_and_evict();
		test_lookup_and_ack();
		test_mixed_traffic(700);
		test_back_to_back(400);
		test_urgent_flood(400);
		test_clock_wrap(400);

		// Drop valid after the last transaction and drain the replies.
		in_valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("priority_message_slot_table_top: match");
		else
			$display("priority_message_slot_table_top: mismatch");
		$finish;
	end

endmodule
